/* rtl/tkh_pkg.sv */
package tkh_pkg;

  localparam int SCORE_W   = 32;
  localparam int IN_PL_W   = 64;
  localparam int POS_W     = 5;
  localparam int HELD_W    = 5;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic        [IN_PL_W-1:0] payload;
  } tkh_in_t;

  typedef struct packed {
    logic                      accepted;
    logic        [POS_W-1:0]   position;
    logic        [HELD_W-1:0]  held_count;
    logic                      is_full;
    logic signed [SCORE_W-1:0] entry_boundary;
  } tkh_out_t;

  // Per-cell control: cmp_en latches the compare flags, wr_en applies the insertion.
  typedef struct packed {
    logic cmp_en;
    logic wr_en;
  } tkh_ctrl_t;

  typedef enum logic {
    PH_IDLE,
    PH_UPD
  } tkh_phase_e;

endpackage

/* rtl/top_k_score_hold.sv */
// Holds the best CAPACITY scored entries in descending score order.
// Input channel: present a candidate on in_i (score, payload) and raise
// start_i; the transfer happens at a rising edge where start_i is high and
// busy_o is low. busy_o stays high through the update phase that follows the transfer.
// Result channel: done_o is high for exactly one cycle, registered in done_q
// from the update phase, and result_o carries acceptance, position, held count,
// the full flag and the entry boundary in that cycle only. The receiver
// cannot hold results off, so it must take each one as it appears.
// No new candidate is taken until the last is through. At the transfer each
// cell latches the compare of its held entry with the candidate; in the
// update phase the insertion point and duplicate check are resolved; if
// accepted, each cell below that point takes its upper neighbour's entry at once.
// Reset clears the held count and the control state; the store contents are
// not cleared, since only entries below the held count are ever looked at.
module top_k_score_hold #(
  parameter int CAPACITY     = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tkh_pkg::tkh_in_t  in_i,
  output logic              done_o,
  output tkh_pkg::tkh_out_t result_o
);
  import tkh_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  tkh_phase_e phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;

  logic signed [SCORE_W-1:0] cand_score_q;
  logic [PAYLOAD_BITS-1:0]   cand_payload_q;
  logic [PAYLOAD_BITS-1:0]   in_payload;

  logic                      in_xfer;
  tkh_ctrl_t                 ctrl;

  logic [CAPACITY-1:0]       above_w;
  logic [CAPACITY-1:0]       match_w;
  logic [CAPACITY-1:0]       prev_above;
  logic signed [SCORE_W-1:0] score_w      [CAPACITY];
  logic [PAYLOAD_BITS-1:0]   payload_w    [CAPACITY];
  logic signed [SCORE_W-1:0] prev_score   [CAPACITY];
  logic [PAYLOAD_BITS-1:0]   prev_payload [CAPACITY];

  logic [CAPACITY:0]         above_ext;
  logic                      dup;
  logic [CW-1:0]             place;
  logic                      acc;

  logic                      done_q;
  logic                      res_acc_q;
  logic [CW-1:0]             res_place_q;
  logic [CW-1:0]             res_cnt_q;
  logic                      res_full_q;

  assign in_payload = in_i.payload[PAYLOAD_BITS-1:0];
  assign busy_o     = (phase_q != PH_IDLE);
  assign in_xfer    = start_i && !busy_o;

  // The held entries with a score at least the candidate's form a prefix of
  // the chain, so the insertion point is the end of that prefix.
  always_comb begin
    above_ext = {1'b0, above_w};
    dup       = 1'b0;
    place     = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (above_ext[i] && !above_ext[i+1]) begin
        dup   = dup | match_w[i];
        place = place | CW'(i + 1);
      end
    end
    acc = !above_w[CAPACITY-1] && !dup;
  end

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    ctrl.cmp_en = 1'b0;
    ctrl.wr_en  = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_xfer) begin
          ctrl.cmp_en = 1'b1;
          phase_d     = PH_UPD;
        end
      end
      PH_UPD: begin
        ctrl.wr_en = acc;
        if (acc && (count_q != CW'(CAPACITY))) begin
          count_d = count_q + CW'(1);
        end
        phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      done_q  <= (phase_q == PH_UPD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cand_score_q   <= in_i.score;
      cand_payload_q <= in_payload;
    end
    if (phase_q == PH_UPD) begin
      res_acc_q   <= acc;
      res_place_q <= acc ? place : CW'(CAPACITY);
      res_cnt_q   <= count_d;
      res_full_q  <= (count_d == CW'(CAPACITY));
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_above[g]   = 1'b1;
      assign prev_score[g]   = '0;
      assign prev_payload[g] = '0;
    end else begin : g_link
      assign prev_above[g]   = above_w[g-1];
      assign prev_score[g]   = score_w[g-1];
      assign prev_payload[g] = payload_w[g-1];
    end

    tkh_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .occupied_i    (CW'(g) < count_q),
      .cmp_score_i   (in_i.score),
      .cmp_payload_i (in_payload),
      .new_score_i   (cand_score_q),
      .new_payload_i (cand_payload_q),
      .above_prev_i  (prev_above[g]),
      .prev_score_i  (prev_score[g]),
      .prev_payload_i(prev_payload[g]),
      .above_o       (above_w[g]),
      .match_o       (match_w[g]),
      .score_o       (score_w[g]),
      .payload_o     (payload_w[g])
    );
  end

  assign done_o                  = done_q;
  assign result_o.accepted       = res_acc_q;
  assign result_o.position       = POS_W'(res_place_q);
  assign result_o.held_count     = HELD_W'(res_cnt_q);
  assign result_o.is_full        = res_full_q;
  assign result_o.entry_boundary = res_full_q ? score_w[CAPACITY-1] : SCORE_MIN;

  a_done_follows_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(phase_q == PH_UPD))
    else $error("result strobe without a preceding update cycle");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("held count beyond capacity");

  a_accept_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_acc_q) |-> (res_place_q < CW'(CAPACITY)))
    else $error("accepted candidate placed outside the store");

  a_reject_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !res_acc_q) |-> (count_q == $past(count_q)))
    else $error("rejected candidate changed the held count");

endmodule

/* rtl/tkh_cell.sv */
module tkh_cell #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tkh_pkg::tkh_ctrl_t                  ctrl_i,
  input  logic                                occupied_i,
  input  logic signed [tkh_pkg::SCORE_W-1:0]  cmp_score_i,
  input  logic        [PAYLOAD_BITS-1:0]      cmp_payload_i,
  input  logic signed [tkh_pkg::SCORE_W-1:0]  new_score_i,
  input  logic        [PAYLOAD_BITS-1:0]      new_payload_i,
  input  logic                                above_prev_i,
  input  logic signed [tkh_pkg::SCORE_W-1:0]  prev_score_i,
  input  logic        [PAYLOAD_BITS-1:0]      prev_payload_i,
  output logic                                above_o,
  output logic                                match_o,
  output logic signed [tkh_pkg::SCORE_W-1:0]  score_o,
  output logic        [PAYLOAD_BITS-1:0]      payload_o
);
  import tkh_pkg::*;

  logic                      above_q, above_d;
  logic                      match_q, match_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic [PAYLOAD_BITS-1:0]   payload_q, payload_d;

  always_comb begin
    above_d   = above_q;
    match_d   = match_q;
    score_d   = score_q;
    payload_d = payload_q;
    if (ctrl_i.cmp_en) begin
      above_d = occupied_i && (score_q >= cmp_score_i);
      match_d = (score_q == cmp_score_i) && (payload_q == cmp_payload_i);
    end
    // An entry that stays above the candidate keeps its place; the first one
    // below takes the candidate, and every later one takes its upper neighbour.
    if (ctrl_i.wr_en && !above_q) begin
      if (above_prev_i) begin
        score_d   = new_score_i;
        payload_d = new_payload_i;
      end else begin
        score_d   = prev_score_i;
        payload_d = prev_payload_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      above_q <= above_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q   <= score_d;
    payload_q <= payload_d;
  end

  assign above_o   = above_q;
  assign match_o   = match_q;
  assign score_o   = score_q;
  assign payload_o = payload_q;

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tkh_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int RANDOM_ITEMS = 1180;
  localparam int STALL_LIMIT = 200;
  localparam int DRAIN_CYCLES = 8;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  tkh_in_t  in_i    = '0;
  logic     busy_o;
  logic     done_o;
  tkh_out_t result_o;

  // Candidates waiting to be driven, and outcomes still to arrive.
  tkh_in_t  candidates_due[$];
  tkh_in_t  recent_cands[$];
  tkh_out_t outcomes_due[$];
  tkh_out_t due;

  // Own copy of the ranked store.
  logic signed [SCORE_W-1:0] held_score[CAPACITY];
  logic        [IN_PL_W-1:0] held_payload[CAPACITY];
  int                        held_n = 0;

  int  total_items  = 0;
  int  issued_count = 0;
  int  taken_count  = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  int  errors       = 0;
  int  gap_left     = 0;
  bit  no_gaps      = 1'b0;

  top_k_score_hold #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(IN_PL_W)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .in_i    (in_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #2 clk_i = ~clk_i;

  // Ranks a candidate against the held entries, applies the insertion and
  // returns the outcome that the block should report for it.
  function automatic tkh_out_t rank_and_insert(tkh_in_t cand);
    logic signed [SCORE_W-1:0] sc;
    logic        [IN_PL_W-1:0] pl;
    int                        slot;
    int                        i;
    bit                        twin;
    bit                        placed;
    tkh_out_t                  res;
    sc     = cand.score;
    pl     = cand.payload;
    slot   = held_n;
    placed = 1'b0;
    while (slot > 0 && held_score[slot-1] < sc) slot--;
    twin = slot > 0 && held_score[slot-1] == sc && held_payload[slot-1] == pl;
    if (slot < CAPACITY && !twin) begin
      if (held_n < CAPACITY) held_n++;
      for (i = held_n - 1; i > slot; i--) begin
        held_score[i]   = held_score[i-1];
        held_payload[i] = held_payload[i-1];
      end
      held_score[slot]   = sc;
      held_payload[slot] = pl;
      placed = 1'b1;
    end
    res.accepted       = placed;
    res.position       = placed ? POS_W'(slot) : POS_W'(CAPACITY);
    res.held_count     = HELD_W'(held_n);
    res.is_full        = held_n == CAPACITY;
    res.entry_boundary = (held_n == CAPACITY) ? held_score[CAPACITY-1] : SCORE_MIN;
    return res;
  endfunction

  function automatic logic signed [SCORE_W-1:0] clamp_score(longint v);
    if (v > 64'sd2147483647) return SCORE_MAX;
    if (v < -64'sd2147483648) return SCORE_MIN;
    return v[SCORE_W-1:0];
  endfunction

  task automatic queue_candidate(input logic signed [SCORE_W-1:0] sc,
                                 input logic [IN_PL_W-1:0] pl);
    tkh_in_t cand;
    cand.score   = sc;
    cand.payload = pl;
    candidates_due.push_back(cand);
    recent_cands.push_back(cand);
    if (recent_cands.size() > 8) recent_cands.delete(0);
    total_items++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Driver: a candidate stays on the inputs until its transfer, then a
  // random number of idle cycles follows before the next one.
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || taken_count == issued_count)) begin
      if (start_i) begin
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        gap_left = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (gap_left == 0 && candidates_due.size() != 0) begin
        in_i    <= candidates_due.pop_front();
        start_i <= 1'b1;
        issued_count++;
      end else begin
        if (gap_left != 0) gap_left--;
        start_i <= 1'b0;
        in_i    <= {$urandom(), $urandom(), $urandom()};
      end
    end
  end

  // Monitor: results are checked before the candidate taken at the same
  // edge is ranked, so a result can never match its own candidate.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        results_seen <= results_seen + 1;
        if (outcomes_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, result_o);
        end else begin
          due = outcomes_due.pop_front();
          check_field("accepted", due.accepted, result_o.accepted);
          check_field("position", due.position, result_o.position);
          check_field("held_count", due.held_count, result_o.held_count);
          check_field("is_full", due.is_full, result_o.is_full);
          check_field("entry_boundary", due.entry_boundary, result_o.entry_boundary);
        end
      end
      if (start_i && !busy_o) begin
        outcomes_due.push_back(rank_and_insert(in_i));
        taken_count <= taken_count + 1;
      end
      stall_cycles <= (done_o || (start_i && !busy_o)) ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("top_k_score_hold verification failed");
    $finish;
  end

  initial begin
    longint                    ramp;
    longint                    offset;
    int                        n;
    int                        k;
    int                        roll;
    tkh_in_t                   pick;
    logic signed [SCORE_W-1:0] sc;
    logic        [IN_PL_W-1:0] pl;

    // Directed: empty store, duplicates, ties, extremes, filling up and
    // overflowing the store.
    queue_candidate('0, '0);
    queue_candidate('0, '0);
    queue_candidate('0, 64'd1);
    queue_candidate('0, '0);
    queue_candidate(SCORE_MAX, '1);
    queue_candidate(SCORE_MAX, '1);
    queue_candidate(SCORE_MIN, 64'h5555_5555_5555_5555);
    queue_candidate(SCORE_MIN, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_candidate(SCORE_MIN, 64'hAAAA_AAAA_AAAA_AAAA);
    for (k = 1; k <= 10; k++) queue_candidate(SCORE_W'(k << 16), IN_PL_W'(k));
    queue_candidate(SCORE_MIN, '0);
    queue_candidate(-32'sd1, 64'd7);
    queue_candidate(-32'sd1, 64'd7);
    queue_candidate(SCORE_MAX, '0);

    // Random: scores follow a rising ramp with a spread of a few items, so
    // the store keeps turning over; repeats and ties give duplicates.
    ramp = -64'sd600000000;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      roll   = $urandom_range(0, 99);
      offset = longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000;
      pick   = recent_cands[$urandom_range(0, recent_cands.size() - 1)];
      sc     = clamp_score(ramp + offset);
      pl     = {$urandom(), $urandom()};
      if (roll < 40) begin
        queue_candidate(sc, pl);
      end else if (roll < 60) begin
        queue_candidate(pick.score, pick.payload);
      end else if (roll < 75) begin
        case ($urandom_range(0, 2))
          0:       queue_candidate(pick.score, '0);
          1:       queue_candidate(pick.score, '1);
          default: queue_candidate(pick.score, pl);
        endcase
      end else if (roll < 87) begin
        offset = (longint'($urandom_range(0, 8)) - 4) * 64'sh1_0000;
        queue_candidate(clamp_score(ramp + offset), IN_PL_W'($urandom_range(0, 3)));
      end else if (roll < 95) begin
        queue_candidate($urandom(), pl);
      end else begin
        case ($urandom_range(0, 3))
          0:       queue_candidate(SCORE_MIN, pl);
          1:       queue_candidate(SCORE_MIN + 1, pl);
          2:       queue_candidate(-32'sd1, pl);
          default: queue_candidate('0, pl);
        endcase
      end
      ramp += longint'($urandom_range(0, 4000000));
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (taken_count != total_items || results_seen < total_items) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (outcomes_due.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected %h, actual none",
               $time, outcomes_due.size(), outcomes_due[0]);
    end
    if (errors == 0) begin
      $display("top_k_score_hold verification clean");
    end else begin
      $display("top_k_score_hold verification failed");
    end
    $finish;
  end

endmodule
